### rtl/core/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg: shared types and constants for the link mode sequencer
// Mode and event codes, beat structs and code conversion helpers.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int unsigned CODE_W   = 4;
  localparam int unsigned DWELL_W  = 20;
  localparam int unsigned NUM_MODE = 12;

  localparam logic [DWELL_W-1:0] BOOT_HOLD_MS    = DWELL_W'(100);
  localparam logic [DWELL_W-1:0] SERVER_HOLD_MS  = DWELL_W'(500);
  localparam logic [DWELL_W-1:0] BOTH_HOLD_MS    = DWELL_W'(300);
  localparam logic [DWELL_W-1:0] SEARCH_TMO_RST  = DWELL_W'(10000);
  localparam logic [CODE_W-1:0]  MODE_CODE_MAX   = CODE_W'(NUM_MODE - 1);

  // Event codes
  typedef enum logic [CODE_W-1:0] {
    OP_TICK        = 4'd0,
    OP_EVALUATE    = 4'd1,
    OP_NET_UP      = 4'd2,
    OP_NET_DOWN    = 4'd3,
    OP_PROVISIONED = 4'd4,
    OP_SERVER_UP   = 4'd5,
    OP_LEFT        = 4'd6,
    OP_RIGHT       = 4'd7,
    OP_LINK        = 4'd8,
    OP_UNLINK      = 4'd9,
    OP_FAULT       = 4'd10,
    OP_FORCE       = 4'd11
  } op_t;

  // Sequencer states, one-hot
  typedef enum logic [NUM_MODE-1:0] {
    MODE_BOOT           = 12'b0000_0000_0001,
    MODE_NET_CONNECTING = 12'b0000_0000_0010,
    MODE_NET_CONNECTED  = 12'b0000_0000_0100,
    MODE_PROVISIONING   = 12'b0000_0000_1000,
    MODE_SERVER         = 12'b0000_0001_0000,
    MODE_IDLE           = 12'b0000_0010_0000,
    MODE_LEFT           = 12'b0000_0100_0000,
    MODE_RIGHT          = 12'b0000_1000_0000,
    MODE_BOTH           = 12'b0001_0000_0000,
    MODE_SEARCHING      = 12'b0010_0000_0000,
    MODE_LINKED         = 12'b0100_0000_0000,
    MODE_ERROR          = 12'b1000_0000_0000
  } mode_t;

  // One event beat
  typedef struct packed {
    logic [CODE_W-1:0] op;
    logic              detected;
    logic [CODE_W-1:0] forced_state;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [CODE_W-1:0]  mode;
    logic [CODE_W-1:0]  prior_mode;
    logic               changed;
    logic [DWELL_W-1:0] dwell_ms;
  } result_t;

  // Map a one-hot state to its external code
  function automatic logic [CODE_W-1:0] mode_encode(input mode_t m);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < NUM_MODE; i++) begin
      if (m[i]) begin
        code = code | CODE_W'(i);
      end
    end
    return code;
  endfunction

  // Map an external code to its one-hot state; codes beyond range give boot
  function automatic mode_t mode_decode(input logic [CODE_W-1:0] code);
    mode_t m;
    case (code)
      4'd0:    m = MODE_BOOT;
      4'd1:    m = MODE_NET_CONNECTING;
      4'd2:    m = MODE_NET_CONNECTED;
      4'd3:    m = MODE_PROVISIONING;
      4'd4:    m = MODE_SERVER;
      4'd5:    m = MODE_IDLE;
      4'd6:    m = MODE_LEFT;
      4'd7:    m = MODE_RIGHT;
      4'd8:    m = MODE_BOTH;
      4'd9:    m = MODE_SEARCHING;
      4'd10:   m = MODE_LINKED;
      4'd11:   m = MODE_ERROR;
      default: m = MODE_BOOT;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/lms_in_stage.sv
// ----------------------------------------------------------------------------
// lms_in_stage: event input register
// Captures one event beat and holds it until the sequencer consumes it.
// ----------------------------------------------------------------------------
module lms_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lms_pkg::item_t in_item,
  input  logic           advance,
  output logic           held_valid,
  output lms_pkg::item_t held_item
);
  import lms_pkg::*;

  // Take a new beat when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

### rtl/core/lms_fsm.sv
// ----------------------------------------------------------------------------
// lms_fsm: mode state machine and dwell counter
// Applies one event to the state and forms the result beat for it.
// ----------------------------------------------------------------------------
module lms_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lms_pkg::DWELL_W-1:0]   cfg_wr_data,
  input  logic                          fire,
  input  lms_pkg::item_t                item,
  output lms_pkg::result_t              result
);
  import lms_pkg::*;

  mode_t              mode;
  mode_t              mode_next;
  mode_t              prior;
  mode_t              prior_next;
  logic [DWELL_W-1:0] dwell;
  logic [DWELL_W-1:0] dwell_next;
  logic               left_near;
  logic               left_near_next;
  logic               right_near;
  logic               right_near_next;
  logic [DWELL_W-1:0] search_tmo;

  logic               go;
  mode_t              target;

  // Search timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      search_tmo <= SEARCH_TMO_RST;
    end else if (cfg_wr_en) begin
      search_tmo <= cfg_wr_data;
    end
  end

  // Decide the transition for the current event
  always_comb begin
    go              = 1'b0;
    target          = mode;
    left_near_next  = left_near;
    right_near_next = right_near;
    dwell_next      = dwell;
    case (item.op)
      OP_TICK: begin
        if (dwell != '1) begin
          dwell_next = dwell + DWELL_W'(1);
        end
      end
      OP_EVALUATE: begin
        case (mode)
          MODE_BOOT: begin
            if (dwell > BOOT_HOLD_MS) begin
              go = 1'b1; target = MODE_NET_CONNECTING;
            end
          end
          MODE_SERVER: begin
            if (dwell > SERVER_HOLD_MS) begin
              go = 1'b1; target = MODE_IDLE;
            end
          end
          MODE_IDLE: begin
            if (left_near && right_near) begin
              go = 1'b1; target = MODE_BOTH;
            end else if (left_near) begin
              go = 1'b1; target = MODE_LEFT;
            end else if (right_near) begin
              go = 1'b1; target = MODE_RIGHT;
            end
          end
          MODE_LEFT: begin
            if (!left_near) begin
              go = 1'b1; target = MODE_IDLE;
            end else if (right_near) begin
              go = 1'b1; target = MODE_BOTH;
            end
          end
          MODE_RIGHT: begin
            if (!right_near) begin
              go = 1'b1; target = MODE_IDLE;
            end else if (left_near) begin
              go = 1'b1; target = MODE_BOTH;
            end
          end
          MODE_BOTH: begin
            if (!left_near && !right_near) begin
              go = 1'b1; target = MODE_IDLE;
            end else if (dwell > BOTH_HOLD_MS) begin
              go = 1'b1; target = MODE_SEARCHING;
            end
          end
          MODE_SEARCHING: begin
            if (!left_near || !right_near || (dwell > search_tmo)) begin
              go = 1'b1; target = MODE_IDLE;
            end
          end
          MODE_LINKED: begin
            if (!left_near || !right_near) begin
              go = 1'b1; target = MODE_IDLE;
            end
          end
          default: begin
            go = 1'b0;
          end
        endcase
      end
      OP_NET_UP: begin
        if (mode == MODE_NET_CONNECTING) begin
          go = 1'b1; target = MODE_NET_CONNECTED;
        end
      end
      OP_NET_DOWN: begin
        if (!(mode inside {MODE_ERROR, MODE_NET_CONNECTING})) begin
          go = 1'b1; target = MODE_NET_CONNECTING;
        end
      end
      OP_PROVISIONED: begin
        if (mode == MODE_NET_CONNECTED) begin
          go = 1'b1; target = MODE_PROVISIONING;
        end
      end
      OP_SERVER_UP: begin
        go = 1'b1; target = MODE_SERVER;
      end
      OP_LEFT: begin
        left_near_next = item.detected;
      end
      OP_RIGHT: begin
        right_near_next = item.detected;
      end
      OP_LINK: begin
        if (mode == MODE_SEARCHING) begin
          go = 1'b1; target = MODE_LINKED;
        end
      end
      OP_UNLINK: begin
        if (mode == MODE_LINKED) begin
          go = 1'b1; target = MODE_IDLE;
        end
      end
      OP_FAULT: begin
        go = 1'b1; target = MODE_ERROR;
      end
      OP_FORCE: begin
        if ((item.forced_state <= MODE_CODE_MAX) &&
            (item.forced_state != mode_encode(mode))) begin
          go = 1'b1; target = mode_decode(item.forced_state);
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // Apply the transition: record the prior state
  always_comb begin
    mode_next  = mode;
    prior_next = prior;
    if (go) begin
      mode_next  = target;
      prior_next = mode;
    end
  end

  // Form the result beat from the updated state
  always_comb begin
    result.mode       = mode_encode(mode_next);
    result.prior_mode = mode_encode(prior_next);
    result.changed    = go;
    result.dwell_ms   = go ? '0 : dwell_next;
  end

  // Advance the state when the event is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BOOT;
      prior      <= MODE_BOOT;
      dwell      <= '0;
      left_near  <= 1'b0;
      right_near <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      prior      <= prior_next;
      dwell      <= go ? '0 : dwell_next;
      left_near  <= left_near_next;
      right_near <= right_near_next;
    end
  end

endmodule

### rtl/core/lms_out_stage.sv
// ----------------------------------------------------------------------------
// lms_out_stage: result output register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module lms_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lms_pkg::result_t load_result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output lms_pkg::result_t out_result
);
  import lms_pkg::*;

  // Free when empty or when the held beat leaves this cycle
  assign free = !out_valid || out_ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (free && load) begin
      out_result <= load_result;
    end
  end

endmodule

### rtl/core/link_mode_sequencer.sv
// ----------------------------------------------------------------------------
// link_mode_sequencer: twelve-state link mode sequencer
// An accepted event is held in the input register, and its result beat in the result register.
// Throughput: one event per cycle, set by the input and result registers, while out_ready is high.
// Reset (rst, synchronous): mode and prior mode boot, dwell zero, sensors
// far, search timeout 10000 ms; both pipeline registers empty.
// ----------------------------------------------------------------------------
module link_mode_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lms_pkg::DWELL_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lms_pkg::CODE_W-1:0]  op,
  input  logic                        detected,
  input  logic [lms_pkg::CODE_W-1:0]  forced_state,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lms_pkg::CODE_W-1:0]  mode,
  output logic [lms_pkg::CODE_W-1:0]  prior_mode,
  output logic                        changed,
  output logic [lms_pkg::DWELL_W-1:0] dwell_ms
);
  import lms_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_free;
  logic    advance;
  result_t step_result;
  result_t out_result;

  assign in_item.op           = op;
  assign in_item.detected     = detected;
  assign in_item.forced_state = forced_state;

  // Move the held event on when the result register can take it
  assign advance = held_valid && out_free;

  lms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lms_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .item        (held_item),
    .result      (step_result)
  );

  lms_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .load_result (step_result),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign mode       = out_result.mode;
  assign prior_mode = out_result.prior_mode;
  assign changed    = out_result.changed;
  assign dwell_ms   = out_result.dwell_ms;

  // A transition always restarts the dwell count
  a_change_clears_dwell: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && changed) |-> (dwell_ms == '0)
  ) else $error("transition beat with nonzero dwell");

  // A held event that cannot advance blocks new input
  a_stall_blocks_input: assert property (
    @(posedge clk) disable iff (rst)
    (held_valid && !out_free) |-> !in_ready
  ) else $error("input accepted while held event stalled");

  // Every consumed event produces a result beat
  a_advance_gives_result: assert property (
    @(posedge clk) disable iff (rst)
    advance |=> out_valid
  ) else $error("consumed event produced no result");

endmodule
